@@ hdl/aap_pkg.sv @@
package aap_pkg;

    localparam int MAX_OUT_W_DEF  = 8;
    localparam int MAX_OUT_H_DEF  = 8;
    localparam int MAX_IN_DIM_DEF = 1024;

    localparam int CFG_DIM_W  = 11;
    localparam int CFG_OUT_W  = 4;
    localparam int SAMPLE_W   = 16;
    localparam int QUO_W      = 16;
    localparam int GRID_W     = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_IN_HEIGHT  = 2'd0;
    localparam logic [1:0] REG_IN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_OUT_HEIGHT = 2'd2;
    localparam logic [1:0] REG_OUT_WIDTH  = 2'd3;

    typedef struct packed {
        logic clear;
        logic div_h;
        logic div_w;
        logic ld_kh;
        logic ld_kw;
        logic acc;
        logic prep;
        logic div_avg;
        logic load;
        logic next_col;
        logic next_band;
        logic end_plane;
    } t_cmd;

    typedef struct packed {
        logic band_end;
        logic div_done;
        logic empty;
        logic out_free;
        logic last_col;
        logic more_bands;
        logic plane_end;
    } t_sts;

endpackage

@@ hdl/aap_div.sv @@
module aap_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 22
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [DVD_W-1:0]           i_dividend,
    input  logic        [DVS_W-1:0]           i_divisor,
    output logic                              o_done,
    output logic signed [aap_pkg::QUO_W-1:0]  o_quotient
);

    localparam int QW    = aap_pkg::QUO_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DVD_W-1:0] mag;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [QW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_done;

    // quotient magnitude stays below 2^16, so the upper part starts as remainder
    assign mag   = i_dividend[DVD_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign trial = {r_rem, r_quo[QW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(mag >> QW);
            r_quo <= mag[QW-1:0];
            r_dvs <= i_divisor;
            r_neg <= i_dividend[DVD_W-1];
        end else if (r_cnt != '0) begin
            if (fits) begin
                r_rem <= diff[DVS_W-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= trial[DVS_W-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

@@ hdl/aap_dp.sv @@
module aap_dp #(
    parameter int MAX_OUT_W  = aap_pkg::MAX_OUT_W_DEF,
    parameter int MAX_OUT_H  = aap_pkg::MAX_OUT_H_DEF,
    parameter int MAX_IN_DIM = aap_pkg::MAX_IN_DIM_DEF,
    parameter int DIM_W      = $clog2(MAX_IN_DIM + 1),
    parameter int OW_W       = $clog2(MAX_OUT_W + 1),
    parameter int OH_W       = $clog2(MAX_OUT_H + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  aap_pkg::t_cmd                        i_cmd,
    output aap_pkg::t_sts                        o_sts,
    input  logic [DIM_W-1:0]                     i_h,
    input  logic [DIM_W-1:0]                     i_w,
    input  logic [OH_W-1:0]                      i_oh,
    input  logic [OW_W-1:0]                      i_ow,
    input  logic signed [aap_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_out_ready,
    output logic                                 o_valid,
    output logic signed [aap_pkg::SAMPLE_W-1:0]  o_average,
    output logic [aap_pkg::GRID_W-1:0]           o_grid_row,
    output logic [aap_pkg::GRID_W-1:0]           o_grid_col,
    output logic                                 o_plane_done
);

    localparam int IDX_W  = (MAX_OUT_W > 1) ? $clog2(MAX_OUT_W) : 1;
    localparam int AREA_W = 2 * DIM_W;
    localparam int SUM_W  = aap_pkg::QUO_W + AREA_W;
    localparam int ST_W   = $clog2(MAX_IN_DIM + MAX_OUT_W + 1);
    localparam int END_W  = ST_W + 1;
    localparam int SW     = aap_pkg::SAMPLE_W;

    logic [DIM_W-1:0]        r_kh;
    logic [DIM_W-1:0]        r_kw;
    logic [DIM_W-1:0]        r_col;
    logic [DIM_W-1:0]        r_row;
    logic [DIM_W-1:0]        r_rib;
    logic [DIM_W-1:0]        r_ciw;
    logic [OW_W-1:0]         r_wci;
    logic [OH_W-1:0]         r_band;
    logic [OW_W-1:0]         r_j;
    logic [ST_W-1:0]         r_start;
    logic [DIM_W-1:0]        r_emit_rows;
    logic                    r_pend;
    logic [AREA_W-1:0]       r_area;
    logic                    r_empty;
    logic signed [SUM_W-1:0] r_sum [MAX_OUT_W];

    logic                    r_ovalid;
    logic signed [SW-1:0]    r_avg;
    logic [aap_pkg::GRID_W-1:0] r_grow;
    logic [aap_pkg::GRID_W-1:0] r_gcol;
    logic                    r_pdone;

    logic [DIM_W:0]          col_inc;
    logic [DIM_W:0]          row_inc;
    logic [DIM_W:0]          rib_inc;
    logic [DIM_W:0]          ciw_inc;
    logic                    row_end;
    logic                    plane_end;
    logic                    band_end;
    logic                    win_end;
    logic                    wci_ok;
    logic [IDX_W-1:0]        rd_idx;
    logic signed [SUM_W-1:0] sum_rd;
    logic signed [SUM_W-1:0] s_ext;
    logic [END_W-1:0]        end_pos;
    logic [END_W-1:0]        end_clip;
    logic [END_W-1:0]        cw_big;
    logic [DIM_W-1:0]        cw;
    logic                    more_bands;
    logic                    last_col;
    logic                    out_free;
    logic                    div_start;
    logic signed [SUM_W-1:0] dvd;
    logic [AREA_W-1:0]       dvs;
    logic                    div_done;
    logic signed [aap_pkg::QUO_W-1:0] quo;

    assign col_inc   = (DIM_W+1)'(r_col) + 1'b1;
    assign row_inc   = (DIM_W+1)'(r_row) + 1'b1;
    assign rib_inc   = (DIM_W+1)'(r_rib) + 1'b1;
    assign ciw_inc   = (DIM_W+1)'(r_ciw) + 1'b1;
    assign row_end   = (col_inc >= {1'b0, i_w});
    assign plane_end = (row_inc >= {1'b0, i_h});
    assign band_end  = row_end && ((rib_inc >= {1'b0, r_kh}) || plane_end);
    assign win_end   = (ciw_inc >= {1'b0, r_kw});
    assign wci_ok    = ((OW_W+1)'(r_wci) < (OW_W+1)'(MAX_OUT_W));

    assign rd_idx = i_cmd.acc ? r_wci[IDX_W-1:0] : r_j[IDX_W-1:0];
    assign sum_rd = r_sum[rd_idx];
    assign s_ext  = {{(SUM_W-SW){i_sample[SW-1]}}, i_sample};

    // clipped width of the current output column's window
    assign end_pos  = END_W'(r_start) + END_W'(r_kw);
    assign end_clip = (end_pos > END_W'(i_w)) ? END_W'(i_w) : end_pos;
    assign cw_big   = (end_clip > END_W'(r_start)) ? (end_clip - END_W'(r_start)) : '0;
    assign cw       = cw_big[DIM_W-1:0];

    assign more_bands = r_pend && (((OH_W+1)'(r_band) + 1'b1) < {1'b0, i_oh});
    assign last_col   = (((OW_W+1)'(r_j) + 1'b1) == {1'b0, i_ow});
    assign out_free   = !r_ovalid || i_out_ready;

    always_comb begin
        if (i_cmd.div_h) begin
            dvd = SUM_W'(i_h) + SUM_W'(i_oh) - 1'b1;
            dvs = AREA_W'(i_oh);
        end else if (i_cmd.div_w) begin
            dvd = SUM_W'(i_w) + SUM_W'(i_ow) - 1'b1;
            dvs = AREA_W'(i_ow);
        end else begin
            dvd = sum_rd;
            dvs = r_area;
        end
    end

    assign div_start = i_cmd.div_h || i_cmd.div_w || i_cmd.div_avg;

    aap_div #(
        .DVD_W (SUM_W),
        .DVS_W (AREA_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_OUT_W; k++) begin
                r_sum[k] <= '0;
            end
        end else if (i_cmd.clear || i_cmd.next_band) begin
            for (int k = 0; k < MAX_OUT_W; k++) begin
                r_sum[k] <= '0;
            end
        end else if (i_cmd.acc && wci_ok) begin
            r_sum[rd_idx] <= sum_rd + s_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kh        <= DIM_W'(1);
            r_kw        <= DIM_W'(1);
            r_col       <= '0;
            r_row       <= '0;
            r_rib       <= '0;
            r_ciw       <= '0;
            r_wci       <= '0;
            r_band      <= '0;
            r_j         <= '0;
            r_start     <= '0;
            r_emit_rows <= '0;
            r_pend      <= 1'b0;
        end else if (i_cmd.clear) begin
            r_col       <= '0;
            r_row       <= '0;
            r_rib       <= '0;
            r_ciw       <= '0;
            r_wci       <= '0;
            r_band      <= '0;
            r_j         <= '0;
            r_start     <= '0;
            r_emit_rows <= '0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cmd.ld_kh) begin
                r_kh <= quo[DIM_W-1:0];
            end
            if (i_cmd.ld_kw) begin
                r_kw <= quo[DIM_W-1:0];
            end
            if (i_cmd.acc) begin
                if (row_end) begin
                    r_col <= '0;
                    r_wci <= '0;
                    r_ciw <= '0;
                    if (band_end) begin
                        r_rib       <= '0;
                        r_emit_rows <= rib_inc[DIM_W-1:0];
                        r_j         <= '0;
                        r_start     <= '0;
                    end else begin
                        r_rib <= rib_inc[DIM_W-1:0];
                    end
                    if (plane_end) begin
                        r_row  <= '0;
                        r_pend <= 1'b1;
                    end else begin
                        r_row <= row_inc[DIM_W-1:0];
                    end
                end else begin
                    r_col <= col_inc[DIM_W-1:0];
                    if (win_end) begin
                        r_ciw <= '0;
                        r_wci <= r_wci + 1'b1;
                    end else begin
                        r_ciw <= ciw_inc[DIM_W-1:0];
                    end
                end
            end
            if (i_cmd.next_col) begin
                r_j     <= r_j + 1'b1;
                r_start <= r_start + ST_W'(r_kw);
            end
            if (i_cmd.next_band) begin
                r_j         <= '0;
                r_start     <= '0;
                r_emit_rows <= '0;
                r_band      <= i_cmd.end_plane ? '0 : r_band + 1'b1;
            end
            if (i_cmd.end_plane) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_area  <= AREA_W'(r_emit_rows) * AREA_W'(cw);
            r_empty <= (r_emit_rows == '0) || (cw == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_avg   <= r_empty ? '0 : quo;
            r_grow  <= aap_pkg::GRID_W'(r_band);
            r_gcol  <= aap_pkg::GRID_W'(r_j);
            r_pdone <= r_pend && !more_bands && last_col;
        end
    end

    assign o_sts.band_end   = band_end;
    assign o_sts.div_done   = div_done;
    assign o_sts.empty      = r_empty;
    assign o_sts.out_free   = out_free;
    assign o_sts.last_col   = last_col;
    assign o_sts.more_bands = more_bands;
    assign o_sts.plane_end  = r_pend;

    assign o_valid      = r_ovalid;
    assign o_average    = r_avg;
    assign o_grid_row   = r_grow;
    assign o_grid_col   = r_gcol;
    assign o_plane_done = r_pdone;

endmodule

@@ hdl/aap_ctrl.sv @@
module aap_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr,
    input  logic          i_valid,
    output logic          o_ready,
    input  aap_pkg::t_sts i_sts,
    output aap_pkg::t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_INIT_H = 9'b000000001,
        S_WAIT_H = 9'b000000010,
        S_INIT_W = 9'b000000100,
        S_WAIT_W = 9'b000001000,
        S_IDLE   = 9'b000010000,
        S_PREP   = 9'b000100000,
        S_DIVS   = 9'b001000000,
        S_DIVW   = 9'b010000000,
        S_LOAD   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_H;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT_H: begin
                o_cmd.div_h = 1'b1;
                n_state     = S_WAIT_H;
            end
            S_WAIT_H: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_kh = 1'b1;
                    n_state     = S_INIT_W;
                end
            end
            S_INIT_W: begin
                o_cmd.div_w = 1'b1;
                n_state     = S_WAIT_W;
            end
            S_WAIT_W: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_kw = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_sts.band_end) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIVS;
            end
            S_DIVS: begin
                if (i_sts.empty) begin
                    n_state = S_LOAD;
                end else begin
                    o_cmd.div_avg = 1'b1;
                    n_state       = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.last_col) begin
                        o_cmd.next_band = 1'b1;
                        if (i_sts.more_bands) begin
                            n_state = S_PREP;
                        end else begin
                            o_cmd.end_plane = i_sts.plane_end;
                            n_state         = S_IDLE;
                        end
                    end else begin
                        o_cmd.next_col = 1'b1;
                        n_state        = S_PREP;
                    end
                end
            end
            default: begin
                n_state = S_INIT_H;
            end
        endcase
        // register write restarts the plane and the window size setup
        if (i_cfg_wr) begin
            o_cmd       = '0;
            o_cmd.clear = 1'b1;
            n_state     = S_INIT_H;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ hdl/adaptive_average_pool_2d.sv @@
// channel   direction  handshake                    payload
// sample    in         i_valid / o_ready            i_sample
// result    out        o_valid / i_ready            o_average, o_grid_row, o_grid_col,
//                                                   o_plane_done
// config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// a sample is taken without a stall unless it closes a band of rows
// a closing sample adds, per output column, a multiply and a pass of the 16-step divider;
// an empty window skips the divider, which is shared with the window size setup
// after reset and after each register write the window sizes are derived with the same
// divider, with o_ready low
// a finished result waits in the output register; the next result is loaded only once that slot is free
module adaptive_average_pool_2d #(
    parameter int MAX_OUT_W  = aap_pkg::MAX_OUT_W_DEF,
    parameter int MAX_OUT_H  = aap_pkg::MAX_OUT_H_DEF,
    parameter int MAX_IN_DIM = aap_pkg::MAX_IN_DIM_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [aap_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [aap_pkg::SAMPLE_W-1:0]  o_average,
    output logic [aap_pkg::GRID_W-1:0]           o_grid_row,
    output logic [aap_pkg::GRID_W-1:0]           o_grid_col,
    output logic                                 o_plane_done,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aap_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [aap_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [aap_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int DIM_W = $clog2(MAX_IN_DIM + 1);
    localparam int OW_W  = $clog2(MAX_OUT_W + 1);
    localparam int OH_W  = $clog2(MAX_OUT_H + 1);
    localparam int CDW   = aap_pkg::CFG_DIM_W;
    localparam int COW   = aap_pkg::CFG_OUT_W;
    localparam int DW    = aap_pkg::APB_DATA_W;

    logic [CDW-1:0] r_in_height;
    logic [CDW-1:0] r_in_width;
    logic [COW-1:0] r_out_height;
    logic [COW-1:0] r_out_width;

    logic             cfg_wr;
    logic [1:0]       reg_idx;
    logic [DIM_W-1:0] h_c;
    logic [DIM_W-1:0] w_c;
    logic [OH_W-1:0]  oh_c;
    logic [OW_W-1:0]  ow_c;

    aap_pkg::t_cmd s_cmd;
    aap_pkg::t_sts s_sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height  <= CDW'(1);
            r_in_width   <= CDW'(1);
            r_out_height <= COW'(1);
            r_out_width  <= COW'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                aap_pkg::REG_IN_HEIGHT:  r_in_height  <= pwdata[CDW-1:0];
                aap_pkg::REG_IN_WIDTH:   r_in_width   <= pwdata[CDW-1:0];
                aap_pkg::REG_OUT_HEIGHT: r_out_height <= pwdata[COW-1:0];
                aap_pkg::REG_OUT_WIDTH:  r_out_width  <= pwdata[COW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            aap_pkg::REG_IN_HEIGHT:  prdata = DW'(r_in_height);
            aap_pkg::REG_IN_WIDTH:   prdata = DW'(r_in_width);
            aap_pkg::REG_OUT_HEIGHT: prdata = DW'(r_out_height);
            aap_pkg::REG_OUT_WIDTH:  prdata = DW'(r_out_width);
            default:                 prdata = '0;
        endcase
    end

    // zero acts as one, oversize values saturate at the build maxima
    assign h_c  = (r_in_height == '0) ? DIM_W'(1) :
                  (32'(r_in_height) > 32'(MAX_IN_DIM)) ? DIM_W'(MAX_IN_DIM) :
                  DIM_W'(r_in_height);
    assign w_c  = (r_in_width == '0) ? DIM_W'(1) :
                  (32'(r_in_width) > 32'(MAX_IN_DIM)) ? DIM_W'(MAX_IN_DIM) :
                  DIM_W'(r_in_width);
    assign oh_c = (r_out_height == '0) ? OH_W'(1) :
                  (32'(r_out_height) > 32'(MAX_OUT_H)) ? OH_W'(MAX_OUT_H) :
                  OH_W'(r_out_height);
    assign ow_c = (r_out_width == '0) ? OW_W'(1) :
                  (32'(r_out_width) > 32'(MAX_OUT_W)) ? OW_W'(MAX_OUT_W) :
                  OW_W'(r_out_width);

    aap_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sts    (s_sts),
        .o_cmd    (s_cmd)
    );

    aap_dp #(
        .MAX_OUT_W  (MAX_OUT_W),
        .MAX_OUT_H  (MAX_OUT_H),
        .MAX_IN_DIM (MAX_IN_DIM),
        .DIM_W      (DIM_W),
        .OW_W       (OW_W),
        .OH_W       (OH_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .i_h          (h_c),
        .i_w          (w_c),
        .i_oh         (oh_c),
        .i_ow         (ow_c),
        .i_sample     (i_sample),
        .i_out_ready  (i_ready),
        .o_valid      (o_valid),
        .o_average    (o_average),
        .o_grid_row   (o_grid_row),
        .o_grid_col   (o_grid_col),
        .o_plane_done (o_plane_done)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load |-> s_sts.out_free)
        else $error("result loaded over an untaken transaction");

    a_div_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.div_avg |-> !s_sts.empty)
        else $error("division started for an empty window");

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> !o_ready)
        else $error("sample taken before window sizes were recomputed");

endmodule
